### rtl/dcfr_pkg.sv
// Shared types and constants for the daisy-chain frame relay.
// Used by every module of the block; depends on nothing else.
package dcfr_pkg;

  localparam int BUFFER_DEPTH = 32;
  localparam int PTR_W        = $clog2(BUFFER_DEPTH);
  localparam int OCC_W        = PTR_W + 1;
  localparam int LEVEL_W      = 6;
  localparam int CMP_W        = (OCC_W > LEVEL_W) ? OCC_W : LEVEL_W;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QIDX_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SAMPLE_W     = 10;
  localparam int FRAME_LEN    = 6;
  localparam int LIDX_W       = 3;

  localparam logic [LEVEL_W-1:0] LEVEL_RESET = LEVEL_W'(10);

  // Marker codes in the top three bits of a received byte.
  localparam logic [2:0] MARK_DIG_BEGIN = 3'b100;
  localparam logic [2:0] MARK_DIG_END   = 3'b101;
  localparam logic [2:0] MARK_AMT_BEGIN = 3'b010;
  localparam logic [2:0] MARK_AMT_END   = 3'b011;
  localparam logic [2:0] MARK_ADC_BEGIN = 3'b110;
  localparam logic [2:0] MARK_ADC_END   = 3'b111;

  localparam logic [7:0] DIG_BEGIN_BYTE = 8'h80;
  localparam logic [7:0] DIG_END_BYTE   = 8'hA0;
  localparam logic [7:0] AMT_BEGIN_BYTE = 8'h40;
  localparam logic [7:0] AMT_LOW_BYTE   = 8'h08;
  localparam logic [7:0] AMT_END_BYTE   = 8'h63;
  localparam logic [7:0] ADC_BEGIN_BYTE = 8'hC0;
  localparam logic [7:0] ADC_END_BYTE   = 8'hE0;

  typedef enum logic [2:0] {
    MK_NONE,
    MK_DIG_BEGIN,
    MK_DIG_END,
    MK_AMT_BEGIN,
    MK_AMT_END,
    MK_ADC_BEGIN,
    MK_ADC_END
  } mark_t;

  typedef enum logic [3:0] {
    MODE_IDLE     = 4'd0,
    MODE_DIG_PASS = 4'd1,
    MODE_DIG_FILL = 4'd2,
    MODE_DIG_SEND = 4'd3,
    MODE_AMT_PASS = 4'd4,
    MODE_AMT_FILL = 4'd5,
    MODE_AMT_SEND = 4'd6,
    MODE_ADC_PASS = 4'd7,
    MODE_ADC_FILL = 4'd8,
    MODE_ADC_SEND = 4'd9
  } mode_t;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    logic                is_slot;
    mark_t               mark;
    logic [7:0]          rx_byte;
    logic                clear_to_send;
    logic [7:0]          switch_state;
    logic [SAMPLE_W-1:0] analog_first;
    logic [SAMPLE_W-1:0] analog_second;
    logic [SAMPLE_W-1:0] analog_third;
  } item_t;

endpackage

### rtl/dcfr_front.sv
// Front end: takes input items off the slave stream and decodes the marker.
// Depends on dcfr_pkg; feeds dcfr_queue.
module dcfr_front
  import dcfr_pkg::*;
(
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic        s_axis_tuser,
  input  logic [47:0] s_axis_tdata,
  input  logic        queue_full,
  output logic        push,
  output item_t       push_item
);

  logic [7:0] rx;

  assign rx            = s_axis_tdata[7:0];
  assign s_axis_tready = !queue_full;
  assign push          = s_axis_tvalid && !queue_full;

  always_comb begin
    push_item               = '0;
    push_item.is_slot       = s_axis_tuser;
    push_item.rx_byte       = rx;
    push_item.clear_to_send = s_axis_tdata[8];
    push_item.switch_state  = s_axis_tdata[16:9];
    push_item.analog_first  = s_axis_tdata[26:17];
    push_item.analog_second = s_axis_tdata[36:27];
    push_item.analog_third  = s_axis_tdata[46:37];
    // Markers only matter for received bytes.
    if (s_axis_tuser) begin
      push_item.mark = MK_NONE;
    end else begin
      case (rx[7:5])
        MARK_DIG_BEGIN: push_item.mark = MK_DIG_BEGIN;
        MARK_DIG_END:   push_item.mark = MK_DIG_END;
        MARK_AMT_BEGIN: push_item.mark = MK_AMT_BEGIN;
        MARK_AMT_END:   push_item.mark = MK_AMT_END;
        MARK_ADC_BEGIN: push_item.mark = MK_ADC_BEGIN;
        MARK_ADC_END:   push_item.mark = MK_ADC_END;
        default:        push_item.mark = MK_NONE;
      endcase
    end
  end

endmodule

### rtl/dcfr_queue.sv
// Short queue of classified items between the front and the back.
// Depends on dcfr_pkg.
module dcfr_queue
  import dcfr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t head
);

  item_t             entries [QUEUE_DEPTH];
  logic [QIDX_W-1:0] wr_idx;
  logic [QIDX_W-1:0] rd_idx;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_idx];

  function automatic logic [QIDX_W-1:0] idx_advance(input logic [QIDX_W-1:0] i);
    return (i == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + QIDX_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_idx] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_idx <= idx_advance(wr_idx);
      end
      if (pop) begin
        rd_idx <= idx_advance(rd_idx);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

### rtl/dcfr_back.sv
// Back end: ring buffer, relay mode sequencing, local frame and output register.
// Depends on dcfr_pkg; reads items from dcfr_queue.
module dcfr_back
  import dcfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [LEVEL_W-1:0] cfg_data,
  input  logic               q_not_empty,
  input  item_t              q_head,
  output logic               q_pop,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic               m_axis_tuser,
  output logic [15:0]        m_axis_tdata
);

  logic [7:0]         ring [BUFFER_DEPTH];
  logic [PTR_W-1:0]   write_pointer, write_pointer_next;
  logic [PTR_W-1:0]   read_pointer, read_pointer_next;
  mode_t              relay_mode, relay_mode_next;
  logic               passed_token, passed_token_next;
  logic               send_enabled, send_enabled_next;
  logic [7:0]         local_frame [FRAME_LEN];
  logic [7:0]         local_frame_next [FRAME_LEN];
  logic [LIDX_W-1:0]  local_index, local_index_next;
  logic [LEVEL_W-1:0] release_level;

  logic               out_valid;
  logic               out_tx_valid;
  logic [7:0]         out_byte;
  logic               out_flow;

  logic               tx_valid_next;
  logic [7:0]         tx_byte_next;
  logic               flow_next;
  logic               ring_we;
  logic [7:0]         ring_rd;
  logic [OCC_W-1:0]   occupancy;

  function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign q_pop   = q_not_empty && (!out_valid || m_axis_tready);
  assign ring_we = q_pop && !q_head.is_slot;

  always_comb begin
    mode_t             m;
    logic              en;
    logic [LIDX_W-1:0] idx;
    logic [7:0]        b;
    logic [PTR_W-1:0]  r_adv;

    write_pointer_next = write_pointer;
    read_pointer_next  = read_pointer;
    relay_mode_next    = relay_mode;
    passed_token_next  = passed_token;
    send_enabled_next  = send_enabled;
    local_index_next   = local_index;
    for (int k = 0; k < FRAME_LEN; k++) begin
      local_frame_next[k] = local_frame[k];
    end
    tx_valid_next = 1'b0;
    tx_byte_next  = 8'h00;
    b             = ring_rd;
    r_adv         = ptr_advance(read_pointer);
    m             = relay_mode;
    en            = send_enabled;
    idx           = local_index;

    if (!q_head.is_slot) begin
      write_pointer_next = ptr_advance(write_pointer);
      case (q_head.mark)
        MK_DIG_BEGIN: begin
          read_pointer_next = write_pointer;
          relay_mode_next   = MODE_DIG_PASS;
          send_enabled_next = 1'b1;
        end
        MK_AMT_BEGIN: begin
          read_pointer_next = write_pointer;
          relay_mode_next   = MODE_AMT_PASS;
          send_enabled_next = 1'b1;
        end
        MK_ADC_BEGIN: begin
          read_pointer_next = write_pointer;
          relay_mode_next   = MODE_ADC_PASS;
          send_enabled_next = 1'b1;
        end
        MK_DIG_END: begin
          if (relay_mode != MODE_DIG_PASS) begin
            relay_mode_next   = MODE_DIG_FILL;
            passed_token_next = 1'b0;
          end else begin
            send_enabled_next = 1'b1;
          end
        end
        MK_AMT_END: begin
          if (relay_mode != MODE_AMT_PASS) begin
            relay_mode_next   = MODE_AMT_FILL;
            passed_token_next = 1'b0;
          end else begin
            send_enabled_next = 1'b1;
          end
        end
        MK_ADC_END: begin
          if (relay_mode != MODE_ADC_PASS) begin
            relay_mode_next   = MODE_ADC_FILL;
            passed_token_next = 1'b0;
          end else begin
            send_enabled_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else begin
      // A pending local frame is built at the first slot, busy downstream or not.
      case (relay_mode)
        MODE_DIG_FILL: begin
          local_frame_next[0] = (passed_token ? 8'h00 : DIG_BEGIN_BYTE)
                                | {5'd0, q_head.switch_state[7:5]};
          local_frame_next[1] = DIG_END_BYTE | {3'd0, q_head.switch_state[4:0]};
          m   = MODE_DIG_SEND;
          en  = 1'b1;
          idx = '0;
        end
        MODE_AMT_FILL: begin
          local_frame_next[0] = (passed_token ? 8'h00 : AMT_BEGIN_BYTE) | AMT_LOW_BYTE;
          local_frame_next[1] = AMT_END_BYTE;
          m   = MODE_AMT_SEND;
          en  = 1'b1;
          idx = '0;
        end
        MODE_ADC_FILL: begin
          local_frame_next[0] = (passed_token ? 8'h00 : ADC_BEGIN_BYTE)
                                | {3'd0, q_head.analog_first[9:5]};
          local_frame_next[1] = {3'd0, q_head.analog_first[4:0]};
          local_frame_next[2] = {3'd0, q_head.analog_second[9:5]};
          local_frame_next[3] = {3'd0, q_head.analog_second[4:0]};
          local_frame_next[4] = {3'd0, q_head.analog_third[9:5]};
          local_frame_next[5] = ADC_END_BYTE | {3'd0, q_head.analog_third[4:0]};
          m   = MODE_ADC_SEND;
          en  = 1'b1;
          idx = '0;
        end
        default: begin
        end
      endcase
      relay_mode_next   = m;
      send_enabled_next = en;
      local_index_next  = idx;

      if (q_head.clear_to_send && en) begin
        case (m)
          MODE_DIG_PASS, MODE_AMT_PASS, MODE_ADC_PASS: begin
            tx_valid_next     = 1'b1;
            read_pointer_next = r_adv;
            if (b[5]) begin
              case (m)
                MODE_DIG_PASS: relay_mode_next = MODE_DIG_FILL;
                MODE_AMT_PASS: relay_mode_next = MODE_AMT_FILL;
                default:       relay_mode_next = MODE_ADC_FILL;
              endcase
              passed_token_next = 1'b1;
              b                 = b & 8'h1F;
              send_enabled_next = 1'b0;
            end
            if (r_adv == write_pointer) begin
              send_enabled_next = 1'b0;
            end
            tx_byte_next = b;
          end
          MODE_DIG_SEND, MODE_AMT_SEND, MODE_ADC_SEND: begin
            tx_valid_next    = 1'b1;
            tx_byte_next     = (idx < LIDX_W'(FRAME_LEN))
                               ? local_frame_next[idx[LIDX_W-1:0]] : 8'h00;
            local_index_next = idx + LIDX_W'(1);
            if ((m == MODE_ADC_SEND && idx >= LIDX_W'(FRAME_LEN - 1))
                || (m != MODE_ADC_SEND && idx >= LIDX_W'(1))) begin
              relay_mode_next   = MODE_IDLE;
              send_enabled_next = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
    end

    // Occupancy after the step, counted modulo the buffer depth.
    if (write_pointer_next >= read_pointer_next) begin
      occupancy = OCC_W'(write_pointer_next) - OCC_W'(read_pointer_next);
    end else begin
      occupancy = OCC_W'(write_pointer_next) + OCC_W'(BUFFER_DEPTH)
                  - OCC_W'(read_pointer_next);
    end
    flow_next = (CMP_W'(occupancy) < CMP_W'(release_level));
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[write_pointer] <= q_head.rx_byte;
    end
    if (q_pop) begin
      // The read data always holds the entry under the next read pointer,
      // taking the byte being written when both point at the same entry.
      if (ring_we && (write_pointer == read_pointer_next)) begin
        ring_rd <= q_head.rx_byte;
      end else begin
        ring_rd <= ring[read_pointer_next];
      end
      for (int k = 0; k < FRAME_LEN; k++) begin
        local_frame[k] <= local_frame_next[k];
      end
      out_tx_valid <= tx_valid_next;
      out_byte     <= tx_byte_next;
      out_flow     <= flow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
      relay_mode    <= MODE_IDLE;
      passed_token  <= 1'b0;
      send_enabled  <= 1'b0;
      local_index   <= '0;
      release_level <= LEVEL_RESET;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        release_level <= cfg_data;
      end
      if (q_pop) begin
        write_pointer <= write_pointer_next;
        read_pointer  <= read_pointer_next;
        relay_mode    <= relay_mode_next;
        passed_token  <= passed_token_next;
        send_enabled  <= send_enabled_next;
        local_index   <= local_index_next;
        out_valid     <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_tx_valid;
  assign m_axis_tdata  = {7'd0, out_flow, out_byte};

endmodule

### rtl/daisy_chain_frame_relay.sv
// Daisy-chain frame relay: top level joining front end, item queue and back end.
// An accepted item is written into the queue; the back end step then writes its result into the output register.
// Throughput: one item per cycle while the output is not held by m_axis_tready.
// The two-entry queue and the output register let input and output stall apart.
// Synchronous active-high reset empties the queue and output, clears pointers
// and mode, and sets the release level to 10; ring and local frame are not cleared.
module daisy_chain_frame_relay
  import dcfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // tuser: req_type
  input  logic               s_axis_tuser,
  // tdata: rx_byte[7:0], clear_to_send[8], switch_state[16:9], analog_first[26:17],
  //        analog_second[36:27], analog_third[46:37], zero pad [47]
  input  logic [47:0]        s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // tuser: tx_valid
  output logic               m_axis_tuser,
  // tdata: tx_byte[7:0], flow_ok[8], zero pad [15:9]
  output logic [15:0]        m_axis_tdata,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LEVEL_W-1:0] cfg_data
);

  logic  q_full;
  logic  q_push;
  item_t q_push_item;
  logic  q_pop;
  logic  q_not_empty;
  item_t q_head;

  assign cfg_ready = 1'b1;

  dcfr_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .queue_full    (q_full),
    .push          (q_push),
    .push_item     (q_push_item)
  );

  dcfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  dcfr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .q_not_empty   (q_not_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
